// File: hdl/assert_macros.svh
// Assertion macros shared by the comparator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define ACP_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define ACP_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/acp_pkg.sv
// Types and constants for the analog comparator peripheral.
package acp_pkg;

    // Item kinds
    localparam logic [1:0] ACT_WRITE = 2'd0;
    localparam logic [1:0] ACT_READ  = 2'd1;
    localparam logic [1:0] ACT_PIN   = 2'd2;

    // Bus register map
    localparam logic [1:0] REG_CTRL   = 2'd0;
    localparam logic [1:0] REG_MUX    = 2'd1;
    localparam logic [1:0] REG_IE     = 2'd2;
    localparam logic [1:0] REG_STATUS = 2'd3;

    // Configuration register indexes
    localparam logic CFG_VREF = 1'b0;
    localparam logic CFG_DAC  = 1'b1;

    // Negative input choices (mux bits 1:0)
    localparam logic [1:0] NEG_PIN0 = 2'd0;
    localparam logic [1:0] NEG_PIN1 = 2'd1;
    localparam logic [1:0] NEG_VREF = 2'd2;
    localparam logic [1:0] NEG_DAC  = 2'd3;

    // Edge modes (control bits 5:4)
    localparam logic [1:0] EDGE_BOTH = 2'd0;
    localparam logic [1:0] EDGE_NONE = 2'd1;
    localparam logic [1:0] EDGE_FALL = 2'd2;
    localparam logic [1:0] EDGE_RISE = 2'd3;

    // Bit positions
    localparam int CTRL_EN_BIT   = 0;
    localparam int MUX_INV_BIT   = 7;
    localparam int IE_EN_BIT     = 0;
    localparam int STAT_CLR_BIT  = 0;

    localparam int NUM_POS = 4;
    localparam int NUM_NEG = 2;

    localparam logic [15:0] VREF_RESET_MV = 16'd1100;

    typedef struct packed {
        logic [1:0]  action;
        logic [1:0]  reg_addr;
        logic [7:0]  write_data;
        logic [2:0]  pin_index;
        logic [15:0] pin_mv;
    } in_word_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic       comp_out;
        logic       out_changed;
        logic       irq_request;
    } out_word_t;

    // Evaluation result handed back to the top level
    typedef struct packed {
        logic live;      // live compare output
        logic changed;   // registered output toggles this word
        logic flag_set;  // edge matched the selected mode
    } eval_t;

endpackage

// File: hdl/acp_eval.sv
// Compare, input select, invert and edge check of the comparator.
module acp_eval (
    input  logic [7:0]     ctrl,
    input  logic [7:0]     mux,
    input  logic [15:0]    pos_mv [acp_pkg::NUM_POS],
    input  logic [15:0]    neg_mv [acp_pkg::NUM_NEG],
    input  logic [15:0]    vref_mv,
    input  logic [15:0]    dac_mv,
    input  logic           last_out,
    input  logic           eval_en,
    output acp_pkg::eval_t res
);

    logic [15:0] pos_sel;
    logic [15:0] neg_sel;
    logic        live;
    logic        edge_ok;

    assign pos_sel = pos_mv[mux[4:3]];

    always_comb
    begin
        case (mux[1:0])
            acp_pkg::NEG_PIN0: neg_sel = neg_mv[0];
            acp_pkg::NEG_PIN1: neg_sel = neg_mv[1];
            acp_pkg::NEG_VREF: neg_sel = vref_mv;
            default:           neg_sel = dac_mv;
        endcase
    end

    assign live = ctrl[acp_pkg::CTRL_EN_BIT] &
                  ((pos_sel > neg_sel) ^ mux[acp_pkg::MUX_INV_BIT]);

    always_comb
    begin
        case (ctrl[5:4])
            acp_pkg::EDGE_BOTH: edge_ok = 1'b1;
            acp_pkg::EDGE_NONE: edge_ok = 1'b0;
            acp_pkg::EDGE_FALL: edge_ok = ~live;
            default:            edge_ok = live;
        endcase
    end

    assign res.live     = live;
    assign res.changed  = eval_en & (live != last_out);
    // disabled output never flags
    assign res.flag_set = eval_en & (live != last_out) & ctrl[acp_pkg::CTRL_EN_BIT] & edge_ok;

endmodule

// File: hdl/analog_comparator_peripheral_core.sv
// Top level of the register-mapped analog comparator peripheral.
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+------------------------------
//  in      | in        | in_valid / in_ready   | in_word  (acp_pkg::in_word_t)
//  out     | out       | out_valid / out_ready | out_word (acp_pkg::out_word_t)
//  cfg     | in        | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// One word per cycle while the output is not stalled: the state update and the
// result are computed in the accepting cycle and registered in the output register.
// in_ready is high whenever the output register is empty or being drained,
// so a stalled consumer holds one result and back-pressures the input only.
// cfg_ready is always high; a new level shows in status reads at once and in
// comp_out on the next evaluating word.
// rst_n is asynchronous, active low; all state but out_word_reg returns to its reset value.
`include "assert_macros.svh"

module analog_comparator_peripheral_core (
    input  logic                clk,
    input  logic                rst_n,

    input  logic                in_valid,
    output logic                in_ready,
    input  acp_pkg::in_word_t   in_word,

    output logic                out_valid,
    input  logic                out_ready,
    output acp_pkg::out_word_t  out_word,

    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic                cfg_index,
    input  logic [15:0]         cfg_data
);

    // Architectural state
    logic [15:0] vref_reg;
    logic [15:0] dac_reg;
    logic [7:0]  ctrl_reg, ctrl_next;
    logic [7:0]  mux_reg,  mux_next;
    logic [7:0]  ie_reg,   ie_next;
    logic        flag_reg, flag_next;
    logic        last_reg, last_next;
    logic [15:0] pos_reg  [acp_pkg::NUM_POS];
    logic [15:0] pos_next [acp_pkg::NUM_POS];
    logic [15:0] neg_reg  [acp_pkg::NUM_NEG];
    logic [15:0] neg_next [acp_pkg::NUM_NEG];

    // Output register
    logic               out_valid_reg;
    acp_pkg::out_word_t out_word_reg, out_word_next;

    logic           accept;
    logic           eval_en;
    logic           flag_clr;
    acp_pkg::eval_t ev;

    assign in_ready  = ~out_valid_reg | out_ready;
    assign accept    = in_valid & in_ready;
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

    // Next-state decode for one word. Reads change nothing, so the
    // evaluator always runs on next-state values and serves status reads.
    always_comb
    begin
        ctrl_next = ctrl_reg;
        mux_next  = mux_reg;
        ie_next   = ie_reg;
        pos_next  = pos_reg;
        neg_next  = neg_reg;
        eval_en   = 1'b0;
        flag_clr  = 1'b0;
        case (in_word.action)
            acp_pkg::ACT_WRITE:
            begin
                case (in_word.reg_addr)
                    acp_pkg::REG_CTRL:
                    begin
                        ctrl_next = in_word.write_data;
                        eval_en   = 1'b1;
                    end
                    acp_pkg::REG_MUX:
                    begin
                        mux_next = in_word.write_data;
                        eval_en  = 1'b1;
                    end
                    acp_pkg::REG_IE:
                        ie_next = in_word.write_data;
                    default:
                        flag_clr = in_word.write_data[acp_pkg::STAT_CLR_BIT];
                endcase
            end
            acp_pkg::ACT_PIN:
            begin
                // pins 0-3 positive, 4-5 negative, 6-7 ignored
                case (in_word.pin_index) inside
                    [3'd0:3'd3]:
                    begin
                        pos_next[in_word.pin_index[1:0]] = in_word.pin_mv;
                        eval_en = 1'b1;
                    end
                    [3'd4:3'd5]:
                    begin
                        neg_next[in_word.pin_index[0]] = in_word.pin_mv;
                        eval_en = 1'b1;
                    end
                    default:
                        eval_en = 1'b0;
                endcase
            end
            default:
                eval_en = 1'b0;
        endcase
    end

    acp_eval u_eval (
        .ctrl     (ctrl_next),
        .mux      (mux_next),
        .pos_mv   (pos_next),
        .neg_mv   (neg_next),
        .vref_mv  (vref_reg),
        .dac_mv   (dac_reg),
        .last_out (last_reg),
        .eval_en  (eval_en),
        .res      (ev)
    );

    assign flag_next = (flag_reg & ~flag_clr) | ev.flag_set;
    assign last_next = eval_en ? ev.live : last_reg;

    always_comb
    begin
        out_word_next.read_data = 8'h00;
        if (in_word.action == acp_pkg::ACT_READ)
        begin
            case (in_word.reg_addr)
                acp_pkg::REG_CTRL: out_word_next.read_data = ctrl_reg;
                acp_pkg::REG_MUX:  out_word_next.read_data = mux_reg;
                acp_pkg::REG_IE:   out_word_next.read_data = ie_reg;
                default:           out_word_next.read_data = {3'b000, ev.live, 3'b000, flag_reg};
            endcase
        end
        out_word_next.comp_out    = last_next;
        out_word_next.out_changed = ev.changed;
        out_word_next.irq_request = flag_next & ie_next[acp_pkg::IE_EN_BIT];
    end

    // State and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_reg      <= '0;
            mux_reg       <= '0;
            ie_reg        <= '0;
            flag_reg      <= 1'b0;
            last_reg      <= 1'b0;
            pos_reg       <= '{default: '0};
            neg_reg       <= '{default: '0};
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                ctrl_reg <= ctrl_next;
                mux_reg  <= mux_next;
                ie_reg   <= ie_next;
                flag_reg <= flag_next;
                last_reg <= last_next;
                pos_reg  <= pos_next;
                neg_reg  <= neg_next;
            end
            if (accept)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            out_word_reg <= out_word_next;
    end

    // Reference levels
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vref_reg <= acp_pkg::VREF_RESET_MV;
            dac_reg  <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                acp_pkg::CFG_VREF: vref_reg <= cfg_data;
                default:           dac_reg  <= cfg_data;
            endcase
        end
    end

    // Held result mirrors the state it was computed from
    `ACP_ASSERT_IMP(a_irq_match, out_valid_reg,
        out_word_reg.irq_request == (flag_reg & ie_reg[acp_pkg::IE_EN_BIT]),
        "irq_request does not match flag and enable")
    `ACP_ASSERT_IMP(a_comp_match, out_valid_reg, out_word_reg.comp_out == last_reg,
        "comp_out does not match stored output")
    `ACP_ASSERT_NXT(a_read_quiet, accept && in_word.action == acp_pkg::ACT_READ,
        !out_word_reg.out_changed && $stable(last_reg) && $stable(flag_reg),
        "read word changed comparator state")
    `ACP_ASSERT_IMP(a_disabled_low, !ctrl_reg[acp_pkg::CTRL_EN_BIT], !last_reg,
        "output high while comparator disabled")
    `ACP_ASSERT_IMP(a_flag_on_accept, $rose(flag_reg), $past(accept),
        "compare flag set without an accepted word")

endmodule
